// ===== sv/msp_pkg.sv =====
// Shared types and codes for the multi-axis step pulse generator.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_STAGE  = 3'd1,
    KIND_COMMIT = 3'd2,
    KIND_KILL   = 3'd3,
    KIND_FLUSH  = 3'd4
  } msp_kind_e;

  localparam int unsigned KindW    = 3;
  localparam int unsigned AxisW    = 2;
  localparam int unsigned StepsW   = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned PscaleW  = 16;
  localparam int unsigned MaskW    = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  // Per-item commands broadcast to every axis.
  typedef struct packed {
    logic             tick;
    logic             stage;
    logic             load;
    logic             drop;
    logic             kill;
    logic [AxisW-1:0] axis;
  } msp_ctrl_t;

  // Move parameters for the axis being staged.
  typedef struct packed {
    logic [StepsW-1:0]  steps;
    logic [PeriodW-1:0] period;
    logic [PscaleW-1:0] postscale;
    logic               direction;
  } msp_stage_t;

  // Status returned by each axis.
  typedef struct packed {
    logic step;
    logic done;
    logic active_q;
    logic enable_q;
    logic active_d;
    logic enable_d;
    logic dir_d;
  } msp_axis_stat_t;

  // One result item, last-declared field in the lowest bits.
  typedef struct packed {
    logic             accepted;
    logic             move_loaded;
    logic             pending_full;
    logic [MaskW-1:0] active_mask;
    logic [MaskW-1:0] enable_mask;
    logic [MaskW-1:0] direction_mask;
    logic [MaskW-1:0] step_mask;
  } msp_result_t;

endpackage

`default_nettype wire

// ===== sv/msp_axis.sv =====
// One axis: staged move, period timer, post-scaler and step counter.
`timescale 1ns / 1ps
`default_nettype none

module msp_axis #(
  parameter int unsigned IDX = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  msp_pkg::msp_ctrl_t         ctrl_i,
  input  msp_pkg::msp_stage_t        stage_i,
  input  wire                        pol_i,
  output msp_pkg::msp_axis_stat_t    stat_o
);

  logic [msp_pkg::StepsW-1:0]  staged_steps_q, staged_steps_d;
  logic [msp_pkg::PeriodW-1:0] staged_period_q, staged_period_d;
  logic [msp_pkg::PscaleW-1:0] staged_pscale_q, staged_pscale_d;
  logic                        staged_dir_q, staged_dir_d;

  logic [msp_pkg::StepsW-1:0]  step_count_q, step_count_d;
  logic [msp_pkg::PeriodW-1:0] timer_top_q, timer_top_d;
  logic [msp_pkg::PeriodW-1:0] timer_count_q, timer_count_d;
  logic [msp_pkg::PscaleW-1:0] ps_reload_q, ps_reload_d;
  logic [msp_pkg::PscaleW-1:0] ps_count_q, ps_count_d;
  logic                        active_q, active_d;
  logic                        enable_q, enable_d;
  logic                        dir_q, dir_d;

  logic                        sel;
  logic                        tick_run;
  logic                        wrap;
  logic [msp_pkg::PscaleW-1:0] ps_dec;
  logic [msp_pkg::StepsW-1:0]  sc_dec;
  logic                        step;
  logic                        done;
  logic                        load_me;

  assign sel      = (32'(ctrl_i.axis) == IDX);
  assign tick_run = ctrl_i.tick && active_q;
  assign wrap     = (timer_count_q >= timer_top_q);
  assign ps_dec   = ps_count_q - 16'd1;
  assign sc_dec   = step_count_q - 32'd1;
  assign step     = tick_run && wrap && (ps_dec == '0);
  assign done     = step && (sc_dec == '0);
  assign load_me  = ctrl_i.load && (staged_steps_q != '0);

  always_comb begin
    staged_steps_d  = staged_steps_q;
    staged_period_d = staged_period_q;
    staged_pscale_d = staged_pscale_q;
    staged_dir_d    = staged_dir_q;
    step_count_d    = step_count_q;
    timer_top_d     = timer_top_q;
    timer_count_d   = timer_count_q;
    ps_reload_d     = ps_reload_q;
    ps_count_d      = ps_count_q;
    active_d        = active_q;
    enable_d        = enable_q;
    dir_d           = dir_q;

    if (tick_run) begin
      if (wrap) begin
        timer_count_d = '0;
        ps_count_d    = ps_dec;
        if (ps_dec == '0) begin
          step_count_d = sc_dec;
          ps_count_d   = ps_reload_q;
          if (sc_dec == '0) begin
            active_d = 1'b0;
            enable_d = 1'b0;
          end
        end
      end else begin
        timer_count_d = timer_count_q + 16'd1;
      end
    end

    if (ctrl_i.kill) begin
      active_d = 1'b0;
    end

    // Load overrides the tick update of the same item.
    if (load_me) begin
      step_count_d  = staged_steps_q;
      timer_top_d   = staged_period_q;
      timer_count_d = '0;
      ps_reload_d   = staged_pscale_q;
      ps_count_d    = staged_pscale_q;
      dir_d         = staged_dir_q ^ pol_i;
      enable_d      = 1'b1;
      active_d      = 1'b1;
    end

    if (ctrl_i.drop) begin
      staged_steps_d = '0;
    end
    if (ctrl_i.stage && sel) begin
      staged_steps_d  = stage_i.steps;
      staged_period_d = stage_i.period;
      staged_pscale_d = stage_i.postscale;
      staged_dir_d    = stage_i.direction;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_steps_q <= '0;
      active_q       <= 1'b0;
      enable_q       <= 1'b0;
      dir_q          <= 1'b0;
    end else begin
      staged_steps_q <= staged_steps_d;
      active_q       <= active_d;
      enable_q       <= enable_d;
      dir_q          <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    staged_period_q <= staged_period_d;
    staged_pscale_q <= staged_pscale_d;
    staged_dir_q    <= staged_dir_d;
    step_count_q    <= step_count_d;
    timer_top_q     <= timer_top_d;
    timer_count_q   <= timer_count_d;
    ps_reload_q     <= ps_reload_d;
    ps_count_q      <= ps_count_d;
  end

  always_comb begin
    stat_o.step     = step;
    stat_o.done     = done;
    stat_o.active_q = active_q;
    stat_o.enable_q = enable_q;
    stat_o.active_d = active_d;
    stat_o.enable_d = enable_d;
    stat_o.dir_d    = dir_d;
  end

endmodule

`default_nettype wire

// ===== sv/msp_out_buf.sv =====
// Two-entry result buffer that decouples the output stream from the core.
`timescale 1ns / 1ps
`default_nettype none

module msp_out_buf (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  msp_pkg::msp_result_t  push_data_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire                   ready_i,
  output msp_pkg::msp_result_t  data_o
);

  msp_pkg::msp_result_t mem_q [2];
  logic [1:0]           count_q, count_d;
  logic                 wr_ptr_q, rd_ptr_q;
  logic                 pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_axis_step_pulse_generator_top.sv =====
// Top level of the multi-axis step pulse generator: request register, control, axes.
// A request is held in the request register, and its result is registered in the result buffer before it leaves.
// Throughput: one request per cycle while the result buffer has a free slot; the request register and the two-entry
// result buffer keep the input ready while the last result waits downstream.
// Reset clears all axes, the pending move, the polarity register and the buffer.
`timescale 1ns / 1ps
`default_nettype none

module multi_axis_step_pulse_generator_top #(
  parameter int unsigned AXES = 3
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Requests
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // [1:0] axis, [33:2] steps, [49:34] period, [65:50] postscale,
  // [66] direction, [71:67] zero
  input  wire [msp_pkg::InDataW-1:0]     s_axis_tdata,
  // [2:0] kind
  input  wire [msp_pkg::KindW-1:0]       s_axis_tuser,
  // Results
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [2:0] step_mask, [5:3] direction_mask, [8:6] enable_mask,
  // [11:9] active_mask, [12] pending_full, [13] move_loaded,
  // [14] accepted, [15] zero
  output logic [msp_pkg::OutDataW-1:0]   m_axis_tdata,
  // Polarity register write
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [msp_pkg::MaskW-1:0]       cfg_data_i
);

  // Request register
  logic                        req_valid_q;
  logic [msp_pkg::KindW-1:0]   req_kind_q;
  logic [msp_pkg::AxisW-1:0]   req_axis_q;
  msp_pkg::msp_stage_t         req_stage_q;

  logic [msp_pkg::MaskW-1:0]   polarity_q;
  logic                        pending_q, pending_d;

  logic                        buf_full;
  logic                        fire;
  logic                        load;
  logic                        accepted;

  msp_pkg::msp_ctrl_t          ctrl;
  msp_pkg::msp_axis_stat_t     stat [AXES];
  msp_pkg::msp_result_t        res;
  msp_pkg::msp_result_t        out_res;

  logic [AXES-1:0]             active_vec;
  logic [AXES-1:0]             enable_vec;
  logic [AXES-1:0]             done_vec;
  logic [msp_pkg::MaskW-1:0]   step_m, dir_m, en_m, act_m;

  // Process the held request whenever the result buffer has a free slot.
  assign fire          = req_valid_q && !buf_full;
  assign s_axis_tready = !req_valid_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      polarity_q  <= '0;
      pending_q   <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        req_valid_q <= s_axis_tvalid;
      end
      if (cfg_valid_i) begin
        polarity_q <= cfg_data_i;
      end
      if (fire) begin
        pending_q <= pending_d;
      end
    end
  end

  // Hold the request payload until it is processed.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_kind_q            <= s_axis_tuser;
      req_axis_q            <= s_axis_tdata[1:0];
      req_stage_q.steps     <= s_axis_tdata[33:2];
      req_stage_q.period    <= s_axis_tdata[49:34];
      req_stage_q.postscale <= s_axis_tdata[65:50];
      req_stage_q.direction <= s_axis_tdata[66];
    end
  end

  // Decode the request kind. A load is tried after a tick (against the axes
  // left active by that tick) and right after a commit.
  always_comb begin
    ctrl      = '0;
    ctrl.axis = req_axis_q;
    load      = 1'b0;
    accepted  = 1'b1;
    pending_d = pending_q;
    unique case (req_kind_q)
      msp_pkg::KIND_TICK: begin
        ctrl.tick = fire;
        load      = pending_q && ((active_vec & ~done_vec) == '0);
      end
      msp_pkg::KIND_STAGE: begin
        accepted   = !pending_q;
        ctrl.stage = fire && !pending_q;
      end
      msp_pkg::KIND_COMMIT: begin
        accepted = !pending_q;
        if (!pending_q) begin
          pending_d = 1'b1;
          load      = (active_vec == '0);
        end
      end
      msp_pkg::KIND_KILL: begin
        ctrl.kill = fire;
        ctrl.drop = fire;
        pending_d = 1'b0;
      end
      msp_pkg::KIND_FLUSH: begin
        ctrl.drop = fire;
        pending_d = 1'b0;
      end
      default: begin
        // Undefined kinds change nothing.
      end
    endcase
    // Loading consumes the pending move and clears every staged count.
    if (load) begin
      pending_d = 1'b0;
      ctrl.drop = fire;
    end
    ctrl.load = fire && load;
  end

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    logic pol;
    if (i < msp_pkg::MaskW) begin : g_pol
      assign pol = polarity_q[i];
    end else begin : g_nopol
      assign pol = 1'b0;
    end

    msp_axis #(
      .IDX (i)
    ) u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .stage_i (req_stage_q),
      .pol_i   (pol),
      .stat_o  (stat[i])
    );

    assign active_vec[i] = stat[i].active_q;
    assign enable_vec[i] = stat[i].enable_q;
    assign done_vec[i]   = stat[i].done;
  end

  // Report only the axes that fit in the fixed-width masks.
  for (genvar j = 0; j < msp_pkg::MaskW; j++) begin : g_mask
    if (j < AXES) begin : g_on
      assign step_m[j] = stat[j].step;
      assign dir_m[j]  = stat[j].dir_d;
      assign en_m[j]   = stat[j].enable_d;
      assign act_m[j]  = stat[j].active_d;
    end else begin : g_off
      assign step_m[j] = 1'b0;
      assign dir_m[j]  = 1'b0;
      assign en_m[j]   = 1'b0;
      assign act_m[j]  = 1'b0;
    end
  end

  always_comb begin
    res.step_mask      = step_m;
    res.direction_mask = dir_m;
    res.enable_mask    = en_m;
    res.active_mask    = act_m;
    res.pending_full   = pending_d;
    res.move_loaded    = load;
    res.accepted       = accepted;
  end

  msp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res};

`ifndef NO_ASSERTIONS
  // A move loads only when no axis remains active after the current item.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> ((active_vec & ~done_vec) == '0))
    else $error("move loaded while an axis is still active");

  // A load always empties the pending buffer.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |=> !pending_q)
    else $error("pending buffer still full after a load");

  // An active axis always has its driver enabled.
  a_active_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_vec & ~enable_vec) == '0)
    else $error("axis active with driver disabled");
`endif

endmodule

`default_nettype wire
